>>> hdl/ols_pkg.sv
// Shared types, codes and sizes for the ordered list store.
package ols_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 7;

	typedef enum logic [2:0] {
		OP_INSERT_AT   = 3'd0,
		OP_ERASE_FIRST = 3'd1,
		OP_ERASE_AT    = 3'd2,
		OP_ERASE_NTH   = 3'd3,
		OP_COUNT       = 3'd4,
		OP_READ        = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BADPOS   = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		op_t                      operation;
		logic signed [VAL_W-1:0]  item_value;
		logic [POS_W-1:0]         position;
		logic [POS_W-1:0]         occurrence;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  read_value;
		logic [CNT_W-1:0]         match_count;
		logic [CNT_W-1:0]         occupancy;
	} res_t;

	typedef struct packed {
		logic    load;
		logic    scan_init;
		logic    scan_step;
		logic    down_init;
		logic    down_from_slot;
		logic    down_step;
		logic    up_init;
		logic    up_step;
		logic    rd_step;
		logic    finish;
		logic    take_rd;
		logic    take_cnt;
		logic    fill_inc;
		logic    fill_dec;
		status_t status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic ins_bad;
		logic del_bad;
		logic rd_bad;
		logic scan_more;
		logic up_more;
		logic pipe_busy;
		logic found;
	} stat_t;

endpackage

>>> hdl/ols_dp.sv
// Datapath: entry memory, walk pointer, match counter, fill count and result register.
module ols_dp import ols_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output res_t  res
);

	typedef enum logic [1:0] {K_SCAN, K_DOWN, K_UP, K_READ} kind_t;

	logic [VAL_W-1:0] mem [CAPACITY];

	req_t             req_q;
	res_t             res_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_next;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] ptr_m1;
	logic [CNT_W-1:0] hits_q;
	logic             found_q;
	logic [IDX_W-1:0] slot_q;
	logic             v_s1;
	kind_t            kind_s1;
	logic [IDX_W-1:0] addr_s1;
	logic [VAL_W-1:0] rd_data_s1;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [POS_W-1:0] pos_m1;
	logic [CNT_W:0]   hits_inc;
	logic [CNT_W:0]   target;
	logic             hit;
	kind_t            kind_d;

	assign ptr_m1   = ptr_q - 1'b1;
	assign pos_m1   = req_q.position - 1'b1;
	assign hits_inc = {1'b0, hits_q} + 1'b1;

	always_comb begin
		case (req_q.operation)
			OP_ERASE_FIRST: target = (CNT_W+1)'(1);
			OP_ERASE_NTH:   target = (CNT_W+1)'(req_q.occurrence);
			default:        target = '0;
		endcase
	end

	assign hit = v_s1 && (kind_s1 == K_SCAN) && !found_q
		&& (rd_data_s1 == req_q.item_value[VAL_W-1:0]);

	assign rd_en = cmd.scan_step | cmd.down_step | cmd.up_step | cmd.rd_step;

	always_comb begin
		rd_addr = ptr_q[IDX_W-1:0];
		kind_d  = K_SCAN;
		if (cmd.up_step) begin
			rd_addr = ptr_m1[IDX_W-1:0];
			kind_d  = K_UP;
		end else if (cmd.rd_step) begin
			rd_addr = req_q.position[IDX_W-1:0];
			kind_d  = K_READ;
		end else if (cmd.down_step) begin
			kind_d  = K_DOWN;
		end
	end

	always_comb begin
		wr_en   = v_s1 && (kind_s1 == K_DOWN || kind_s1 == K_UP);
		wr_addr = addr_s1 + 1'b1;
		wr_data = rd_data_s1;
		if (cmd.fill_inc) begin
			wr_en   = 1'b1;
			wr_addr = pos_m1[IDX_W-1:0];
			wr_data = req_q.item_value[VAL_W-1:0];
		end else if (kind_s1 == K_DOWN) begin
			wr_addr = addr_s1 - 1'b1;
		end
	end

	always_comb begin
		fill_next = fill_q;
		if (cmd.fill_inc)
			fill_next = fill_q + 1'b1;
		else if (cmd.fill_dec)
			fill_next = fill_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
		if (rd_en) begin
			addr_s1 <= rd_addr;
			kind_s1 <= kind_d;
		end
		if (hit && hits_inc == target)
			slot_q <= addr_s1;
		if (cmd.finish) begin
			res_q.status      <= cmd.status;
			res_q.read_value  <= cmd.take_rd ? rd_data_s1 : '0;
			res_q.match_count <= cmd.take_cnt ? hits_q : '0;
			res_q.occupancy   <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ptr_q   <= '0;
			hits_q  <= '0;
			found_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			fill_q <= fill_next;
			v_s1   <= rd_en;
			if (cmd.scan_init) begin
				ptr_q   <= '0;
				hits_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (hit) begin
					hits_q <= hits_q + 1'b1;
					if (hits_inc == target)
						found_q <= 1'b1;
				end
				if (cmd.down_init)
					ptr_q <= cmd.down_from_slot ? CNT_W'(slot_q) + 1'b1 : req_q.position;
				else if (cmd.up_init)
					ptr_q <= fill_q;
				else if (cmd.scan_step || cmd.down_step)
					ptr_q <= ptr_q + 1'b1;
				else if (cmd.up_step)
					ptr_q <= ptr_m1;
			end
		end
	end

	always_comb begin
		stat.op        = req_q.operation;
		stat.full      = (fill_q == CNT_W'(CAPACITY));
		stat.ins_bad   = (req_q.position == '0)
			|| ({1'b0, req_q.position} > ({1'b0, fill_q} + 1'b1));
		stat.del_bad   = (req_q.position == '0) || (req_q.position > fill_q);
		stat.rd_bad    = (req_q.position >= fill_q);
		stat.scan_more = (ptr_q < fill_q);
		stat.up_more   = (ptr_q >= req_q.position);
		stat.pipe_busy = v_s1;
		stat.found     = found_q;
	end

	assign res = res_q;

endmodule

>>> hdl/ols_ctrl.sv
// Controller: sequences each request through scan, shift and read steps.
module ols_ctrl import ols_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DOWN,
		S_UP,
		S_RD_WAIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.op)
					OP_INSERT_AT: begin
						if (stat.full) begin
							cmd.finish = 1'b1;
							cmd.status = ST_FULL;
						end else if (stat.ins_bad) begin
							cmd.finish = 1'b1;
							cmd.status = ST_BADPOS;
						end else begin
							cmd.up_init = 1'b1;
							state_d     = S_UP;
						end
					end
					OP_ERASE_FIRST, OP_ERASE_NTH, OP_COUNT: begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
					OP_ERASE_AT: begin
						if (stat.del_bad) begin
							cmd.finish = 1'b1;
							cmd.status = ST_BADPOS;
						end else begin
							cmd.down_init = 1'b1;
							state_d       = S_DOWN;
						end
					end
					OP_READ: begin
						if (stat.rd_bad) begin
							cmd.finish = 1'b1;
							cmd.status = ST_BADPOS;
						end else begin
							cmd.rd_step = 1'b1;
							state_d     = S_RD_WAIT;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						cmd.status = ST_OK;
					end
				endcase
				if (cmd.finish)
					state_d = S_IDLE;
			end
			S_SCAN: begin
				if (stat.found) begin
					cmd.down_init      = 1'b1;
					cmd.down_from_slot = 1'b1;
					state_d            = S_DOWN;
				end else if (stat.scan_more) begin
					cmd.scan_step = 1'b1;
				end else if (!stat.pipe_busy) begin
					cmd.finish   = 1'b1;
					cmd.take_cnt = (stat.op == OP_COUNT);
					cmd.status   = (stat.op == OP_COUNT) ? ST_OK : ST_NOTFOUND;
					state_d      = S_IDLE;
				end
			end
			S_DOWN: begin
				if (stat.scan_more) begin
					cmd.down_step = 1'b1;
				end else if (!stat.pipe_busy) begin
					cmd.fill_dec = 1'b1;
					cmd.finish   = 1'b1;
					cmd.status   = ST_OK;
					state_d      = S_IDLE;
				end
			end
			S_UP: begin
				if (stat.up_more) begin
					cmd.up_step = 1'b1;
				end else if (!stat.pipe_busy) begin
					cmd.fill_inc = 1'b1;
					cmd.finish   = 1'b1;
					cmd.status   = ST_OK;
					state_d      = S_IDLE;
				end
			end
			S_RD_WAIT: begin
				cmd.finish  = 1'b1;
				cmd.take_rd = 1'b1;
				cmd.status  = ST_OK;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

>>> hdl/ordered_list_store_top.sv
// Top level of the ordered list store: controller plus datapath.
//
// A request beat is taken when start is high and busy is low; busy then stays
// high until the result, which appears on res for exactly one cycle with done
// high and must be taken in that cycle. A rejected request or an unused operation
// code finishes at dispatch, a read does one memory read, a count or a failed
// erase by value scans the whole list, and an insert or an erase by position
// shifts the entries from that position on; an erase by value scans up to its
// match and then shifts the entries behind it down. The entry memory reads one
// entry and writes one entry per cycle while entries are shifted, and only reads
// while the list is scanned. A new request may start in the cycle that done is
// high. The list is empty after reset.
module ordered_list_store_top import ols_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t res
);

	cmd_t  cmd;
	stat_t stat;

	ols_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ols_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res)
	);

endmodule

>>> hdl/ols_chk.sv
// Port checker for the ordered list store, bound to the top level.
module ols_chk import ols_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input res_t res
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted beat");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.occupancy <= CNT_W'(CAPACITY))
		else $error("occupancy beyond capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status != ST_OK |-> res.read_value == '0 && res.match_count == '0)
		else $error("failed request returned data");

endmodule

bind ordered_list_store_top ols_chk u_ols_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);
